### rtl/hupd_pkg.sv
// Shared types and constants for the UART packet deframer.
// No dependencies; every other file refers to this package by scoped names.
package hupd_pkg;

    // Byte and field widths
    localparam int BYTE_W  = 8;
    localparam int KIND_W  = 2;
    localparam int HCNT_W  = 3;
    localparam int LEN_W   = 16;
    localparam int PHASE_W = 2;
    localparam int CFG_IDX_W = 2;

    // Deframer phases
    localparam logic [PHASE_W-1:0] PH_TYPE    = 2'd0;
    localparam logic [PHASE_W-1:0] PH_HEADER  = 2'd1;
    localparam logic [PHASE_W-1:0] PH_PAYLOAD = 2'd2;

    // Packet kinds as reported on the output
    localparam logic [KIND_W-1:0] KIND_COMMAND = 2'd0;
    localparam logic [KIND_W-1:0] KIND_ACL     = 2'd1;
    localparam logic [KIND_W-1:0] KIND_EVENT   = 2'd2;

    // Header lengths after the type byte, and where the length sits in them
    localparam logic [HCNT_W-1:0] CMD_HDR_BYTES   = 3'd3;
    localparam logic [HCNT_W-1:0] ACL_HDR_BYTES   = 3'd4;
    localparam logic [HCNT_W-1:0] EVT_HDR_BYTES   = 3'd2;
    localparam logic [HCNT_W-1:0] CMD_LEN_POS     = 3'd3;
    localparam logic [HCNT_W-1:0] ACL_LEN_LO_POS  = 3'd3;
    localparam logic [HCNT_W-1:0] ACL_LEN_HI_POS  = 3'd4;
    localparam logic [HCNT_W-1:0] EVT_LEN_POS     = 3'd2;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_CMD_CODE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ACL_CODE = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_EVT_CODE = 2'd2;

    // Reset values of the type codes
    localparam logic [BYTE_W-1:0] CMD_CODE_RST = 8'd1;
    localparam logic [BYTE_W-1:0] ACL_CODE_RST = 8'd2;
    localparam logic [BYTE_W-1:0] EVT_CODE_RST = 8'd4;

    // One tagged beat as it travels from the front to the output
    typedef struct packed {
        logic [BYTE_W-1:0] data;
        logic [KIND_W-1:0] kind;
        logic              first;
        logic              last;
        logic              bad;
    } t_beat;

    // Header length for a packet kind; the unused code counts as an event
    function automatic logic [HCNT_W-1:0] hdr_bytes(input logic [KIND_W-1:0] kind);
        logic [HCNT_W-1:0] n;
        unique case (kind)
            KIND_COMMAND: n = CMD_HDR_BYTES;
            KIND_ACL:     n = ACL_HDR_BYTES;
            default:      n = EVT_HDR_BYTES;
        endcase
        return n;
    endfunction

endpackage

### rtl/hci_uart_packet_deframer.sv
// UART host-controller packet deframer. Takes one received byte per beat and hands
// each byte on, tagged with packet kind, first/last marks and a bad-type flag. One
// byte is accepted every clock cycle when downstream keeps up. A byte is written into
// the queue at the edge that accepts it and then loaded into the output register once
// that register is free or being drained, and downstream takes it from there. o_rx_stall
// rises when the QUEUE_DEPTH-entry queue is full, which at the default depth happens only
// because downstream has stalled. Unknown type bytes are still passed out, flagged bad.
module hci_uart_packet_deframer #(
    parameter int QUEUE_DEPTH = 2
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [hupd_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [hupd_pkg::BYTE_W-1:0]     i_cfg_data,
    input  logic                            i_rx_valid,
    input  logic [hupd_pkg::BYTE_W-1:0]     i_rx_byte,
    output logic                            o_rx_stall,
    output logic                            o_out_valid,
    input  logic                            i_out_stall,
    output logic [hupd_pkg::BYTE_W-1:0]     o_out_byte,
    output logic [hupd_pkg::KIND_W-1:0]     o_packet_kind,
    output logic                            o_first_of_packet,
    output logic                            o_last_of_packet,
    output logic                            o_bad_type
);

    logic            rx_accept;
    logic            q_full, q_empty, q_pop;
    hupd_pkg::t_beat front_beat, q_beat, out_beat;

    assign o_rx_stall = q_full;
    assign rx_accept  = i_rx_valid && !q_full;

    hupd_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_accept   (rx_accept),
        .i_rx_byte  (i_rx_byte),
        .o_beat     (front_beat)
    );

    hupd_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (rx_accept),
        .i_push_beat (front_beat),
        .i_pop       (q_pop),
        .o_pop_beat  (q_beat),
        .o_full      (q_full),
        .o_empty     (q_empty)
    );

    hupd_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_queue_empty (q_empty),
        .i_queue_beat  (q_beat),
        .o_pop         (q_pop),
        .i_stall       (i_out_stall),
        .o_valid       (o_out_valid),
        .o_beat        (out_beat)
    );

    // Split the output beat onto its field ports
    assign o_out_byte        = out_beat.data;
    assign o_packet_kind     = out_beat.kind;
    assign o_first_of_packet = out_beat.first;
    assign o_last_of_packet  = out_beat.last;
    assign o_bad_type        = out_beat.bad;

endmodule

### rtl/hupd_front.sv
// Front end: type-code registers, packet phase tracking and beat tagging.
// Uses hupd_pkg for the beat type, phase codes and header layout.
module hupd_front (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [hupd_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [hupd_pkg::BYTE_W-1:0]     i_cfg_data,
    input  logic                            i_accept,
    input  logic [hupd_pkg::BYTE_W-1:0]     i_rx_byte,
    output hupd_pkg::t_beat                 o_beat
);

    logic [hupd_pkg::BYTE_W-1:0]  r_cmd_code, r_acl_code, r_evt_code;
    logic [hupd_pkg::PHASE_W-1:0] r_phase, n_phase;
    logic [hupd_pkg::KIND_W-1:0]  r_kind, n_kind;
    logic [hupd_pkg::HCNT_W-1:0]  r_hdr_cnt, n_hdr_cnt;
    logic [hupd_pkg::BYTE_W-1:0]  r_len_low, n_len_low;
    logic [hupd_pkg::LEN_W-1:0]   r_payload_left, n_payload_left;

    logic [hupd_pkg::HCNT_W-1:0]  hdr_pos;
    logic [hupd_pkg::LEN_W-1:0]   len_new;
    logic [hupd_pkg::KIND_W-1:0]  cur_kind;

    // Hold the type codes; writes to an unused index are ignored
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cmd_code <= hupd_pkg::CMD_CODE_RST;
            r_acl_code <= hupd_pkg::ACL_CODE_RST;
            r_evt_code <= hupd_pkg::EVT_CODE_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                hupd_pkg::CFG_CMD_CODE: r_cmd_code <= i_cfg_data;
                hupd_pkg::CFG_ACL_CODE: r_acl_code <= i_cfg_data;
                hupd_pkg::CFG_EVT_CODE: r_evt_code <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Report the unused kind code as an event
    assign cur_kind = (r_kind == hupd_pkg::KIND_COMMAND || r_kind == hupd_pkg::KIND_ACL)
                      ? r_kind : hupd_pkg::KIND_EVENT;
    assign hdr_pos  = r_hdr_cnt + 3'd1;

    // Classify the incoming byte and work out the next packet state
    always_comb begin
        n_phase        = r_phase;
        n_kind         = r_kind;
        n_hdr_cnt      = r_hdr_cnt;
        n_len_low      = r_len_low;
        n_payload_left = r_payload_left;
        len_new        = r_payload_left;
        o_beat.data    = i_rx_byte;
        o_beat.kind    = hupd_pkg::KIND_COMMAND;
        o_beat.first   = 1'b0;
        o_beat.last    = 1'b0;
        o_beat.bad     = 1'b0;
        unique case (r_phase)
            hupd_pkg::PH_HEADER: begin
                o_beat.kind = cur_kind;
                n_hdr_cnt   = hdr_pos;
                unique case (cur_kind)
                    hupd_pkg::KIND_COMMAND: begin
                        if (hdr_pos == hupd_pkg::CMD_LEN_POS) begin
                            len_new = {8'd0, i_rx_byte};
                        end
                    end
                    hupd_pkg::KIND_ACL: begin
                        if (hdr_pos == hupd_pkg::ACL_LEN_LO_POS) begin
                            n_len_low = i_rx_byte;
                        end else if (hdr_pos == hupd_pkg::ACL_LEN_HI_POS) begin
                            len_new = {i_rx_byte, r_len_low};
                        end
                    end
                    default: begin
                        if (hdr_pos == hupd_pkg::EVT_LEN_POS) begin
                            len_new = {8'd0, i_rx_byte};
                        end
                    end
                endcase
                n_payload_left = len_new;
                // Header complete: an empty payload ends the packet here
                if (hdr_pos >= hupd_pkg::hdr_bytes(cur_kind)) begin
                    if (len_new == '0) begin
                        o_beat.last = 1'b1;
                        n_phase     = hupd_pkg::PH_TYPE;
                    end else begin
                        n_phase     = hupd_pkg::PH_PAYLOAD;
                    end
                end
            end
            hupd_pkg::PH_PAYLOAD: begin
                o_beat.kind    = cur_kind;
                n_payload_left = r_payload_left - 16'd1;
                if (n_payload_left == '0) begin
                    o_beat.last = 1'b1;
                    n_phase     = hupd_pkg::PH_TYPE;
                end
            end
            default: begin
                // Type byte: the command code wins, then ACL, then event
                priority if (i_rx_byte == r_cmd_code) begin
                    o_beat.kind = hupd_pkg::KIND_COMMAND;
                end else if (i_rx_byte == r_acl_code) begin
                    o_beat.kind = hupd_pkg::KIND_ACL;
                end else if (i_rx_byte == r_evt_code) begin
                    o_beat.kind = hupd_pkg::KIND_EVENT;
                end else begin
                    o_beat.bad  = 1'b1;
                end
                if (!o_beat.bad) begin
                    o_beat.first   = 1'b1;
                    n_kind         = o_beat.kind;
                    n_hdr_cnt      = '0;
                    n_len_low      = '0;
                    n_payload_left = '0;
                    n_phase        = hupd_pkg::PH_HEADER;
                end else begin
                    n_phase        = hupd_pkg::PH_TYPE;
                end
            end
        endcase
    end

    // Advance the packet state on each accepted beat
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase        <= hupd_pkg::PH_TYPE;
            r_kind         <= hupd_pkg::KIND_COMMAND;
            r_hdr_cnt      <= '0;
            r_len_low      <= '0;
            r_payload_left <= '0;
        end else if (i_accept) begin
            r_phase        <= n_phase;
            r_kind         <= n_kind;
            r_hdr_cnt      <= n_hdr_cnt;
            r_len_low      <= n_len_low;
            r_payload_left <= n_payload_left;
        end
    end

    // A dropped type byte carries no packet marks
    a_bad_unmarked: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_accept && o_beat.bad) |-> (!o_beat.first && !o_beat.last
                                      && o_beat.kind == hupd_pkg::KIND_COMMAND))
        else $error("dropped type byte carries packet marks");

    // A recognised type byte always opens the header
    a_first_to_header: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_accept && o_beat.first) |=> (r_phase == hupd_pkg::PH_HEADER))
        else $error("type byte did not open a header");

    // The payload phase never sits on an exhausted count
    a_payload_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == hupd_pkg::PH_PAYLOAD) |-> (r_payload_left != '0))
        else $error("payload phase with no bytes left");

endmodule

### rtl/hupd_queue.sv
// Short beat queue between the deframer front and the output stage.
// Uses hupd_pkg for the beat type; depth comes from the top level.
module hupd_queue #(
    parameter int DEPTH = 2
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  hupd_pkg::t_beat i_push_beat,
    input  logic            i_pop,
    output hupd_pkg::t_beat o_pop_beat,
    output logic            o_full,
    output logic            o_empty
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    hupd_pkg::t_beat    r_mem [DEPTH];
    logic [PTR_W-1:0]   r_wr_ptr, r_rd_ptr;
    logic [CNT_W-1:0]   r_count;

    assign o_full     = (r_count == FULL_CNT);
    assign o_empty    = (r_count == '0);
    assign o_pop_beat = r_mem[r_rd_ptr];

    // Store the pushed beat
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_push_beat;
        end
    end

    // Advance pointers and occupancy
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == LAST_PTR) ? '0 : r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= (r_rd_ptr == LAST_PTR) ? '0 : r_rd_ptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (i_pop && !i_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_push && o_full && !i_pop))
        else $error("push into full queue");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_pop && o_empty))
        else $error("pop from empty queue");

    a_count_up: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_push && !i_pop) |=> (r_count == $past(r_count) + CNT_W'(1)))
        else $error("occupancy did not follow a push");

endmodule

### rtl/hupd_back.sv
// Output stage: registers one tagged beat and presents it downstream.
// Uses hupd_pkg for the beat type.
module hupd_back (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_queue_empty,
    input  hupd_pkg::t_beat i_queue_beat,
    output logic            o_pop,
    input  logic            i_stall,
    output logic            o_valid,
    output hupd_pkg::t_beat o_beat
);

    logic            r_valid;
    hupd_pkg::t_beat r_beat;

    // Take the next beat when the output register is free or being drained
    assign o_pop   = !i_queue_empty && (!r_valid || !i_stall);
    assign o_valid = r_valid;
    assign o_beat  = r_beat;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_pop) begin
            r_valid <= 1'b1;
        end else if (!i_stall) begin
            r_valid <= 1'b0;
        end
    end

    // Load payload with the pop
    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_beat <= i_queue_beat;
        end
    end

endmodule
